FILE: sv/crc16_seeded_mask_sealer_core_assert.svh
// Assertion macros used by the sealer checker.
`ifndef CRC16_SEEDED_MASK_SEALER_CORE_ASSERT_SVH
`define CRC16_SEEDED_MASK_SEALER_CORE_ASSERT_SVH

// Clocked assertion with async active-low reset disable.
`define CMSS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cmss assertion failed");

// Same, with a caller-supplied message.
`define CMSS_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

FILE: sv/cmss_pkg.sv
package cmss_pkg;

  typedef enum logic [1:0] {
    FUNC_ABSORB = 2'd0,
    FUNC_SEED   = 2'd1,
    FUNC_MASK   = 2'd2
  } func_e;

  localparam logic [15:0] CrcPoly   = 16'h1021;
  localparam int unsigned HighShift = 31;
  localparam int unsigned LowShift  = 12;
  localparam int unsigned FoldShift = 20;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  data_byte;
    logic [31:0] stored_word;
  } seal_item_t;

  typedef struct packed {
    logic [15:0] crc;
    logic [31:0] low;
    logic [31:0] high;
    logic        pass;
  } seal_state_t;

  typedef struct packed {
    logic [15:0] crc_value;
    logic [31:0] mask_word;
    logic        word_match;
    logic        all_match;
  } seal_res_t;

  // CRC-16/XMODEM, one byte, MSB first.
  function automatic logic [15:0] crc_absorb(logic [15:0] crc, logic [7:0] byte_v);
    logic [15:0] c;
    c = crc ^ {byte_v, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = (c << 1) ^ CrcPoly;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

  function automatic logic [31:0] mask_next_low(logic [31:0] lo, logic [31:0] hi);
    logic [31:0] nx;
    nx = ((hi << HighShift) | (lo >> 1)) ^ (lo << LowShift);
    return nx ^ (nx >> FoldShift);
  endfunction

  function automatic logic [31:0] mask_next_high(logic [31:0] lo, logic [31:0] hi);
    return {hi[30:0], lo[0]};
  endfunction

endpackage

FILE: sv/cmss_in_if.sv
interface cmss_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  data_byte;
  logic [31:0] stored_word;

  modport source (output valid, output func, output data_byte, output stored_word,
                  input ready);
  modport sink (input valid, input func, input data_byte, input stored_word,
                output ready);
endinterface

FILE: sv/cmss_out_if.sv
interface cmss_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] crc_value;
  logic [31:0] mask_word;
  logic        word_match;
  logic        all_match;

  modport source (output valid, output crc_value, output mask_word, output word_match,
                  output all_match, input ready);
  modport sink (input valid, input crc_value, input mask_word, input word_match,
                input all_match, output ready);
endinterface

FILE: sv/cmss_step.sv
module cmss_step import cmss_pkg::*; (
  input  seal_item_t  item_i,
  input  seal_state_t state_i,
  output seal_state_t state_o,
  output seal_res_t   res_o
);

  logic [31:0] gen_low;
  logic        gen_match;

  assign gen_low   = mask_next_low(state_i.low, state_i.high);
  assign gen_match = (gen_low == item_i.stored_word);

  always_comb begin
    state_o = state_i;
    res_o.crc_value  = state_i.crc;
    res_o.mask_word  = state_i.low;
    res_o.word_match = 1'b0;
    unique case (func_e'(item_i.func))
      FUNC_ABSORB: begin
        state_o.crc     = crc_absorb(state_i.crc, item_i.data_byte);
        res_o.crc_value = state_o.crc;
      end
      FUNC_SEED: begin
        state_o.low     = {state_i.crc, state_i.crc};
        state_o.high    = {state_i.crc, state_i.crc};
        state_o.crc     = '0;
        state_o.pass    = 1'b1;
        res_o.mask_word = {state_i.crc, state_i.crc};
      end
      FUNC_MASK: begin
        state_o.low      = gen_low;
        state_o.high     = mask_next_high(state_i.low, state_i.high);
        state_o.pass     = state_i.pass & gen_match;
        res_o.mask_word  = gen_low;
        res_o.word_match = gen_match;
      end
      default: begin
      end
    endcase
    res_o.all_match = state_o.pass;
  end

endmodule

FILE: sv/crc16_seeded_mask_sealer_core.sv
// Channel  | Dir | Word
// ---------+-----+-----------------------------------------------------
// in_i     | in  | func, data_byte, stored_word
// out_o    | out | crc_value, mask_word, word_match, all_match
//
// One word per cycle sustained while the result side is ready; an accepted
// word is held in the input register, then moves into the result register,
// with the CRC/mask step evaluated between them. State (CRC, mask words,
// pass flag) updates as a word moves into the result register, so the next
// word sees it without a bubble. Reset clears CRC and mask words and sets the pass flag.
// A stalled result holds; the input register still fills behind it.
module crc16_seeded_mask_sealer_core import cmss_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  cmss_in_if.sink    in_i,
  cmss_out_if.source out_o
);

  logic        s1_valid_q;
  seal_item_t  item_q;
  logic        out_valid_q;
  seal_res_t   res_q;
  seal_state_t state_q;
  seal_state_t state_d;
  seal_res_t   res_d;
  logic        s1_move;
  logic        in_fire;

  assign s1_move    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_move;
  assign in_fire    = in_i.valid && in_i.ready;

  cmss_step u_step (
    .item_i  (item_q),
    .state_i (state_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{crc: '0, low: '0, high: '0, pass: 1'b1};
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= '{func: in_i.func, data_byte: in_i.data_byte,
                  stored_word: in_i.stored_word};
    end
    if (s1_move) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.crc_value  = res_q.crc_value;
  assign out_o.mask_word  = res_q.mask_word;
  assign out_o.word_match = res_q.word_match;
  assign out_o.all_match  = res_q.all_match;

endmodule

FILE: sv/cmss_chk.sv
`include "crc16_seeded_mask_sealer_core_assert.svh"

module cmss_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] crc_value_i,
  input logic [31:0] mask_word_i,
  input logic        word_match_i,
  input logic        all_match_i
);

  // Stalled result word holds.
  `CMSS_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(crc_value_i) && $stable(mask_word_i) && $stable(word_match_i) && $stable(all_match_i)))

  // A fresh result only follows an accepted input word, by way of the input register.
  `CMSS_ASSERT_MSG(a_out_origin, clk_i, rst_ni, $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2), "result without input word")

  // Pass flag can only come back through a seed, which never reports a match.
  `CMSS_ASSERT_MSG(a_pass_rearm, clk_i, rst_ni, (out_valid_i && out_ready_i && !all_match_i) ##1 (out_valid_i && all_match_i) |-> !word_match_i, "pass flag re-set by mask word")

endmodule

bind crc16_seeded_mask_sealer_core cmss_chk u_cmss_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .crc_value_i  (out_o.crc_value),
  .mask_word_i  (out_o.mask_word),
  .word_match_i (out_o.word_match),
  .all_match_i  (out_o.all_match)
);

FILE: verif/tb.sv
module tb;
  import cmss_pkg::*;

  localparam logic [1:0] FuncIdle   = 2'd3;
  localparam int         HoldCycles = 200;
  localparam int         HoldAfter  = 400;
  localparam int         WordTarget = 940;
  localparam int         ReportMax  = 10;

  class seal_checker;
    seal_state_t state;
    seal_res_t   pending_results[$];
    int          n_checked;
    int          n_errors;
    int          n_seeds;
    int          n_mask_hit;
    int          n_mask_miss;

    function new();
      state       = '0;
      state.pass  = 1'b1;
      n_checked   = 0;
      n_errors    = 0;
      n_seeds     = 0;
      n_mask_hit  = 0;
      n_mask_miss = 0;
    endfunction

    // One step of the sealer: updates st and returns the result word.
    static function seal_res_t advance(inout seal_state_t st, input logic [1:0] fn,
                                       input logic [7:0] b, input logic [31:0] sw);
      seal_res_t   r;
      logic [15:0] c;
      logic [31:0] nx;
      r           = '0;
      r.crc_value = st.crc;
      r.mask_word = st.low;
      case (fn)
        FUNC_ABSORB: begin
          c = st.crc ^ {b, 8'h00};
          for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
          end
          st.crc      = c;
          r.crc_value = c;
        end
        FUNC_SEED: begin
          st.low      = {st.crc, st.crc};
          st.high     = {st.crc, st.crc};
          st.crc      = '0;
          st.pass     = 1'b1;
          r.mask_word = st.low;
        end
        FUNC_MASK: begin
          nx           = {st.high[0], st.low[31:1]} ^ (st.low << LowShift);
          st.high      = {st.high[30:0], st.low[0]};
          st.low       = nx ^ (nx >> FoldShift);
          r.mask_word  = st.low;
          r.word_match = (st.low == sw);
          if (!r.word_match) begin
            st.pass = 1'b0;
          end
        end
        default: begin
        end
      endcase
      r.all_match = st.pass;
      return r;
    endfunction

    function void note_word(logic [1:0] fn, logic [7:0] b, logic [31:0] sw);
      seal_res_t r;
      r = advance(state, fn, b, sw);
      pending_results.push_back(r);
      if (fn == FUNC_SEED) n_seeds++;
      if (fn == FUNC_MASK) begin
        if (r.word_match) n_mask_hit++;
        else n_mask_miss++;
      end
    endfunction

    function void check_result(seal_res_t got);
      seal_res_t exp_r;
      n_checked++;
      if (pending_results.size() == 0) begin
        n_errors++;
        if (n_errors <= ReportMax) begin
          $display("unexpected result word: crc=%h word=%h wm=%b am=%b",
                   got.crc_value, got.mask_word, got.word_match, got.all_match);
        end
        return;
      end
      exp_r = pending_results.pop_front();
      if (got !== exp_r) begin
        n_errors++;
        if (n_errors <= ReportMax) begin
          $display("result %0d mismatch: exp crc=%h word=%h wm=%b am=%b",
                   n_checked, exp_r.crc_value, exp_r.mask_word, exp_r.word_match,
                   exp_r.all_match);
          $display("                      got crc=%h word=%h wm=%b am=%b",
                   got.crc_value, got.mask_word, got.word_match, got.all_match);
        end
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  cmss_in_if  in_if();
  cmss_out_if out_if();

  crc16_seeded_mask_sealer_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  seal_checker board;
  seal_state_t plan_state;
  int          words_sent = 0;
  bit          held_off   = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Drives one word; with want_match set, a mask word carries the expected value.
  task automatic send_word(logic [1:0] fn, logic [7:0] b, logic [31:0] sw, bit want_match);
    seal_state_t probe;
    seal_res_t   r;
    logic [31:0] sw_v;
    int          gap;
    sw_v = sw;
    if (want_match && fn == FUNC_MASK) begin
      probe = plan_state;
      r     = seal_checker::advance(probe, fn, b, sw);
      sw_v  = r.mask_word;
    end
    r = seal_checker::advance(plan_state, fn, b, sw_v);
    in_if.valid       <= 1'b1;
    in_if.func        <= fn;
    in_if.data_byte   <= b;
    in_if.stored_word <= sw_v;
    do @(posedge clk_i); while (!in_if.ready);
    words_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_region();
    int nbytes;
    int nwords;
    nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 8);
    for (int i = 0; i < nbytes; i++) begin
      send_word(FUNC_ABSORB, 8'($urandom), $urandom, 1'b0);
    end
    send_word(FUNC_SEED, 8'($urandom), $urandom, 1'b0);
    nwords = $urandom_range(1, 10);
    for (int i = 0; i < nwords; i++) begin
      send_word(FUNC_MASK, 8'($urandom), $urandom, $urandom_range(0, 19) != 0);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        board.note_word(in_if.func, in_if.data_byte, in_if.stored_word);
      end
      if (out_if.valid && out_if.ready) begin
        board.check_result('{out_if.crc_value, out_if.mask_word, out_if.word_match,
                             out_if.all_match});
      end
    end
  end

  // Result side: random stalls, plus one long hold-off so the block backs up.
  initial begin
    int burst;
    int gap;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!held_off && words_sent >= HoldAfter) begin
        held_off = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      burst = $urandom_range(1, 30);
      out_if.ready <= 1'b1;
      repeat (burst) @(posedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  initial begin
    #12_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int r;
    board            = new();
    plan_state       = '0;
    plan_state.pass  = 1'b1;
    rst_ni           = 1'b0;
    in_if.valid       <= 1'b0;
    in_if.func        <= FUNC_ABSORB;
    in_if.data_byte   <= '0;
    in_if.stored_word <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // unused selector at reset, mask steps before any seed, then absorbs, a seed and mask steps
    send_word(FuncIdle, 8'hA5, 32'h5A5A_5A5A, 1'b0);
    send_word(FUNC_MASK, 8'h00, 32'h0000_0000, 1'b0);
    send_word(FUNC_MASK, 8'hFF, 32'hFFFF_FFFF, 1'b0);
    send_word(FuncIdle, 8'hFF, 32'hFFFF_FFFF, 1'b0);
    send_word(FUNC_ABSORB, 8'hFF, 32'h0000_0000, 1'b0);
    send_word(FUNC_ABSORB, 8'h00, 32'hFFFF_FFFF, 1'b0);
    send_word(FUNC_ABSORB, 8'h80, 32'h8000_0001, 1'b0);
    send_word(FUNC_ABSORB, 8'h01, 32'h7FFF_FFFE, 1'b0);
    send_word(FUNC_SEED, 8'h00, 32'h0000_0000, 1'b0);
    send_word(FUNC_MASK, 8'h00, 32'h0, 1'b1);
    send_word(FUNC_MASK, 8'h00, 32'h0, 1'b1);
    send_word(FUNC_MASK, 8'h00, 32'h0, 1'b1);
    send_word(FUNC_MASK, 8'h00, 32'h0000_0000, 1'b0);
    send_word(FUNC_MASK, 8'h00, 32'h0, 1'b1);
    // seed from a cleared CRC, then absorb restarting from zero
    send_word(FUNC_SEED, 8'hFF, 32'hFFFF_FFFF, 1'b0);
    send_word(FUNC_MASK, 8'h00, 32'h0, 1'b1);
    send_word(FUNC_ABSORB, 8'h00, 32'h0, 1'b0);
    send_word(FUNC_ABSORB, 8'hFF, 32'h0, 1'b0);
    send_word(FUNC_SEED, 8'h00, 32'h0, 1'b0);
    send_word(FUNC_MASK, 8'h00, 32'hFFFF_FFFF, 1'b0);
    send_word(FuncIdle, 8'h5A, 32'hA5A5_A5A5, 1'b0);

    while (words_sent < WordTarget) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        send_region();
      end else begin
        send_word(2'($urandom), 8'($urandom), $urandom, $urandom_range(0, 1) != 0);
      end
    end
    in_if.valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("run: %0d words in, %0d results checked, %0d seeds", words_sent,
             board.n_checked, board.n_seeds);
    $display("run: %0d mask words matched, %0d mismatched, %0d errors", board.n_mask_hit,
             board.n_mask_miss, board.n_errors);
    if (board.n_errors == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/cmss_pkg.sv
sv/cmss_in_if.sv
sv/cmss_out_if.sv
sv/cmss_step.sv
sv/crc16_seeded_mask_sealer_core.sv
sv/cmss_chk.sv
verif/tb.sv
